[rtl/core/pfa_pkg.sv]
package pfa_pkg;

    // Map geometry
    localparam int MAX_PAGES = 32768;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int WORD_W    = 64;
    localparam int WORD_BITS = $clog2(WORD_W);
    localparam int WORDS     = MAX_PAGES / WORD_W;
    localparam int WADDR_W   = $clog2(WORDS);
    localparam int PAGE_SHIFT = 12;

    // Register widths and reset values
    localparam int BASE_W = 32;
    localparam int PCNT_W = 16;
    localparam int RSV_W  = 16;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;
    localparam int ALLOC_W = 16;
    localparam int USED_W  = 17;
    localparam int STAT_W  = 2;

    localparam logic [BASE_W-1:0] BASE_RESET = 32'h0010_0000;
    localparam logic [PCNT_W-1:0] PCNT_RESET = 16'd32768;
    localparam logic [RSV_W-1:0]  RSV_RESET  = 16'd8;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_BASE     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PAGES    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RESERVED = 2'd2;

    // Request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Stream payload widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    // Find-first-zero result of one map word
    typedef struct packed {
        logic                 found;
        logic [WORD_BITS-1:0] pos;
    } ffz_t;

    typedef enum logic [6:0] {
        ST_CLEAR       = 7'b0000001,
        ST_IDLE        = 7'b0000010,
        ST_FREE_CHK    = 7'b0000100,
        ST_FREE_WR     = 7'b0001000,
        ST_ALLOC_START = 7'b0010000,
        ST_ALLOC_SCAN  = 7'b0100000,
        ST_RESP        = 7'b1000000
    } state_t;

endpackage

[rtl/core/pfa_ram.sv]
module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/pfa_ffz.sv]
module pfa_ffz (
    input  logic [pfa_pkg::WORD_W-1:0]    word,
    input  logic                          lo_en,
    input  logic [pfa_pkg::WORD_BITS-1:0] lo_bit,
    input  logic                          hi_en,
    input  logic [pfa_pkg::WORD_BITS-1:0] hi_bit,
    output pfa_pkg::ffz_t                 res
);

    logic [pfa_pkg::WORD_W-1:0] cand;

    // Mark free bits inside the scan window
    always_comb begin
        for (int b = 0; b < pfa_pkg::WORD_W; b++) begin
            cand[b] = !word[b]
                && (!lo_en || (pfa_pkg::WORD_BITS'(b) >= lo_bit))
                && (!hi_en || (pfa_pkg::WORD_BITS'(b) <= hi_bit));
        end
    end

    // Pick the lowest candidate
    always_comb begin
        res.found = |cand;
        res.pos   = '0;
        for (int b = pfa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                res.pos = pfa_pkg::WORD_BITS'(b);
            end
        end
    end

endmodule

[rtl/core/page_frame_allocator.sv]
// Page frame allocator over a one-bit-per-page used map.
// Input stream (s_): one request per transaction; s_tuser carries the kind
// (allocate or free), s_tdata the address to free. Output stream (m_): one
// result per request with page address, status and used page count.
// Configuration: cfg_wr_en/cfg_addr/cfg_data write base address, page count
// and reserved pages; write them only while no request is in flight.
// The map sits in one 64-bit wide RAM with a registered read.
// A free inside the region goes through a check state that reads the map
// word, a write state and a result state; a free outside it goes from the
// check straight to the result state. An allocate reads one 64-page map
// word at a time from the reserved pages upward until it finds a free page or reaches the region's last word.
// One request is in progress at a time; the next is taken once the result
// has moved into the output register, even while it waits there.
// After reset the map is swept clear, one word per cycle, over the whole map;
// no request is accepted then. Configuration resets to base 0x100000,
// 32768 pages and 8 reserved pages.
// When the receiver stalls, the result holds in the output register; one
// more request is taken and its result waits in the sequencer, after which
// the input is held off until the output register empties.
module page_frame_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [pfa_pkg::CIDX_W-1:0]    cfg_addr,
    input  logic [pfa_pkg::CFG_W-1:0]     cfg_data,
    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfa_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] address
    input  logic [0:0]                    s_tuser,   // [0] cmd
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfa_pkg::M_DATA_W-1:0]  m_tdata    // [31:0] page_address,
                                                     // [33:32] status,
                                                     // [50:34] used_pages,
                                                     // [55:51] zero
);

    localparam int IDX_W   = pfa_pkg::IDX_W;
    localparam int CNT_W   = pfa_pkg::CNT_W;
    localparam int WB      = pfa_pkg::WORD_BITS;
    localparam int WADDR_W = pfa_pkg::WADDR_W;
    localparam int WORD_W  = pfa_pkg::WORD_W;
    localparam int PS      = pfa_pkg::PAGE_SHIFT;

    pfa_pkg::state_t state_reg, state_next;

    logic [pfa_pkg::BASE_W-1:0]  base_reg;
    logic [pfa_pkg::PCNT_W-1:0]  pages_reg;
    logic [pfa_pkg::RSV_W-1:0]   rsv_reg;
    logic [pfa_pkg::ALLOC_W-1:0] count_reg, count_next;

    logic [WADDR_W-1:0]          clr_reg, clr_next;
    logic [31:0]                 addr_reg, addr_next;
    logic [WADDR_W-1:0]          chk_reg, chk_next;
    logic [WADDR_W-1:0]          start_reg, start_next;
    logic [IDX_W-1:0]            fidx_reg, fidx_next;
    logic [31:0]                 res_addr_reg, res_addr_next;
    logic [pfa_pkg::STAT_W-1:0]  res_stat_reg, res_stat_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [pfa_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Map RAM ports
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_data;

    // Derived region values
    logic [CNT_W-1:0]   n_pages;
    logic [IDX_W-1:0]   last_idx;
    logic [WADDR_W-1:0] last_word;
    logic               rsv_full;
    logic [32:0]        region_end;
    logic               in_range;
    logic [31:0]        offset;
    logic [IDX_W-1:0]   hit_idx;
    logic [pfa_pkg::USED_W-1:0] used;
    logic               out_free;

    pfa_pkg::ffz_t ffz;

    pfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (pfa_pkg::WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfa_ffz u_ffz (
        .word   (rd_data),
        .lo_en  (chk_reg == start_reg),
        .lo_bit (rsv_reg[WB-1:0]),
        .hi_en  (chk_reg == last_word),
        .hi_bit (last_idx[WB-1:0]),
        .res    (ffz)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= pfa_pkg::BASE_RESET;
            pages_reg <= pfa_pkg::PCNT_RESET;
            rsv_reg   <= pfa_pkg::RSV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pfa_pkg::CFG_BASE:     base_reg  <= cfg_data;
                pfa_pkg::CFG_PAGES:    pages_reg <= cfg_data[pfa_pkg::PCNT_W-1:0];
                pfa_pkg::CFG_RESERVED: rsv_reg   <= cfg_data[pfa_pkg::RSV_W-1:0];
                default: ;
            endcase
        end
    end

    // Region bounds
    always_comb begin
        if (32'(pages_reg) >= 32'(pfa_pkg::MAX_PAGES)) begin
            n_pages = CNT_W'(pfa_pkg::MAX_PAGES);
        end else begin
            n_pages = CNT_W'(pages_reg);
        end
        last_idx   = IDX_W'(n_pages - CNT_W'(1));
        last_word  = last_idx[IDX_W-1:WB];
        rsv_full   = 32'(rsv_reg) >= 32'(n_pages);
        region_end = 33'(base_reg) + (33'(n_pages) << PS);
        in_range   = (addr_reg >= base_reg) && (33'(addr_reg) < region_end);
        offset     = addr_reg - base_reg;
        hit_idx    = {chk_reg, ffz.pos};
        used       = pfa_pkg::USED_W'(rsv_reg) + pfa_pkg::USED_W'(count_reg);
        out_free   = !m_tvalid_reg || m_tready;
    end

    assign s_tready = (state_reg == pfa_pkg::ST_IDLE);

    // Sequencer: clear sweep, free read-modify-write, allocate scan
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        chk_next      = chk_reg;
        start_next    = start_reg;
        fidx_next     = fidx_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = chk_reg;

        unique case (state_reg)
            pfa_pkg::ST_CLEAR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + WADDR_W'(1);
                if (clr_reg == WADDR_W'(pfa_pkg::WORDS - 1)) begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            pfa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    addr_next = s_tdata;
                    if (s_tuser[0] == pfa_pkg::CMD_FREE) begin
                        state_next = pfa_pkg::ST_FREE_CHK;
                    end else begin
                        state_next = pfa_pkg::ST_ALLOC_START;
                    end
                end
            end
            pfa_pkg::ST_FREE_CHK: begin
                res_addr_next = '0;
                if (in_range) begin
                    fidx_next     = offset[IDX_W+PS-1:PS];
                    rd_en         = 1'b1;
                    rd_addr       = offset[IDX_W+PS-1:PS+WB];
                    res_stat_next = pfa_pkg::ST_OK;
                    state_next    = pfa_pkg::ST_FREE_WR;
                end else begin
                    res_stat_next = pfa_pkg::ST_RANGE;
                    state_next    = pfa_pkg::ST_RESP;
                end
            end
            pfa_pkg::ST_FREE_WR: begin
                wr_en   = 1'b1;
                wr_addr = fidx_reg[IDX_W-1:WB];
                wr_data = rd_data & ~(WORD_W'(1) << fidx_reg[WB-1:0]);
                if (count_reg != '0) begin
                    count_next = count_reg - pfa_pkg::ALLOC_W'(1);
                end
                state_next = pfa_pkg::ST_RESP;
            end
            pfa_pkg::ST_ALLOC_START: begin
                if (rsv_full) begin
                    res_addr_next = '0;
                    res_stat_next = pfa_pkg::ST_OOM;
                    state_next    = pfa_pkg::ST_RESP;
                end else begin
                    start_next = rsv_reg[IDX_W-1:WB];
                    chk_next   = rsv_reg[IDX_W-1:WB];
                    rd_en      = 1'b1;
                    rd_addr    = rsv_reg[IDX_W-1:WB];
                    state_next = pfa_pkg::ST_ALLOC_SCAN;
                end
            end
            pfa_pkg::ST_ALLOC_SCAN: begin
                if (ffz.found) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_reg;
                    wr_data = rd_data | (WORD_W'(1) << ffz.pos);
                    if (count_reg != '1) begin
                        count_next = count_reg + pfa_pkg::ALLOC_W'(1);
                    end
                    res_addr_next = base_reg + 32'({hit_idx, PS'(0)});
                    res_stat_next = pfa_pkg::ST_OK;
                    state_next    = pfa_pkg::ST_RESP;
                end else if (chk_reg == last_word) begin
                    res_addr_next = '0;
                    res_stat_next = pfa_pkg::ST_OOM;
                    state_next    = pfa_pkg::ST_RESP;
                end else begin
                    // Prefetch the next word while advancing
                    rd_en    = 1'b1;
                    rd_addr  = chk_reg + WADDR_W'(1);
                    chk_next = chk_reg + WADDR_W'(1);
                end
            end
            pfa_pkg::ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pfa_pkg::M_DATA_W'({used, res_stat_reg, res_addr_reg});
                    state_next    = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfa_pkg::ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        chk_reg      <= chk_next;
        start_reg    <= start_next;
        fidx_reg     <= fidx_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[test/pfa_checker.sv]
module pfa_checker
    import pfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CIDX_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Result layout, highest field first, as it sits on m_tdata
    typedef struct packed {
        logic [4:0]        pad;
        logic [USED_W-1:0] used_pages;
        logic [STAT_W-1:0] status;
        logic [31:0]       page_address;
    } pfa_result_t;

    // Own copy of the registers, the used map and the allocation count
    logic [BASE_W-1:0] region_base;
    logic [PCNT_W-1:0] region_pages;
    logic [RSV_W-1:0]  reserved_count;
    bit                page_busy [MAX_PAGES];
    int unsigned       taken_pages;
    pfa_result_t       awaited_results [$];

    // Serve one request against the local map and return its result
    function automatic pfa_result_t serve_request(input logic cmd, input logic [31:0] addr);
        pfa_result_t r;
        int unsigned n;
        int unsigned idx;
        logic [33:0] lo;
        logic [33:0] hi;
        logic [33:0] offset;
        n = (region_pages < MAX_PAGES) ? region_pages : MAX_PAGES;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_ALLOC) begin
            // take the first free page above the reserved ones
            idx = reserved_count;
            while (idx < n && page_busy[idx])
                idx++;
            if (idx < n) begin
                page_busy[idx] = 1'b1;
                if (taken_pages < 16'hFFFF)
                    taken_pages++;
                r.page_address = region_base + (idx << PAGE_SHIFT);
            end else begin
                r.status = ST_OOM;
            end
        end else begin
            // range check without wrap; the end address is outside
            lo = {2'b00, region_base};
            hi = lo + (34'(n) << PAGE_SHIFT);
            if ({2'b00, addr} >= lo && {2'b00, addr} < hi) begin
                offset = {2'b00, addr} - lo;
                page_busy[offset >> PAGE_SHIFT] = 1'b0;
                if (taken_pages > 0)
                    taken_pages--;
            end else begin
                r.status = ST_RANGE;
            end
        end
        r.used_pages = USED_W'(reserved_count + taken_pages);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Track register writes, predict on each request, compare each result
    always @(posedge aclk) begin : watch
        pfa_result_t got;
        pfa_result_t want;
        if (!aresetn) begin
            region_base    = BASE_RESET;
            region_pages   = PCNT_RESET;
            reserved_count = RSV_RESET;
            taken_pages    = 0;
            foreach (page_busy[i])
                page_busy[i] = 1'b0;
            awaited_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_BASE:     region_base    = cfg_data;
                    CFG_PAGES:    region_pages   = cfg_data[PCNT_W-1:0];
                    CFG_RESERVED: reserved_count = cfg_data[RSV_W-1:0];
                    default:      ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = pfa_result_t'(m_tdata);
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: 0x%0h", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    report_field("page_address", want.page_address, got.page_address);
                    report_field("status", want.status, got.status);
                    report_field("used_pages", want.used_pages, got.used_pages);
                    report_field("pad", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(serve_request(s_tuser[0], s_tdata));
        end
        pending = awaited_results.size();
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int QUIET_TAIL     = 150;
    localparam int RX_HOLD_CYCLES = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CIDX_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    int                   fail_count;
    int                   pending;

    // Stimulus control shared with the receiver
    bit                   quiet;
    bit                   rx_hold_req;
    bit                   hold_done;
    bit                   pause_done;
    int                   items_sent;

    // Region as last written, used to aim free addresses
    logic [31:0]          cur_base;
    int unsigned          cur_pages;
    int unsigned          cur_rsv;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    page_frame_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pfa_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side: short random stalls, one long hold-off on request
    initial begin : receiver
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the transaction completes
    task automatic send_req(input logic cmd, input logic [31:0] addr);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic idle_tx();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        idle_tx();
        wait (pending == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [31:0] base, input int unsigned pages,
                             input int unsigned rsv);
        drain();
        write_reg(CFG_BASE, base);
        write_reg(CFG_PAGES, CFG_W'(pages & 16'hFFFF));
        write_reg(CFG_RESERVED, CFG_W'(rsv & 16'hFFFF));
        cur_base  = base;
        cur_pages = (pages & 16'hFFFF) > MAX_PAGES ? MAX_PAGES : (pages & 16'hFFFF);
        cur_rsv   = rsv & 16'hFFFF;
    endtask

    // Mostly pages inside the region, often near the allocation front; some edges and noise
    function automatic logic [31:0] pick_free_address();
        int unsigned idx;
        int unsigned lo_idx;
        int unsigned hi_idx;
        logic [31:0] page_off;
        page_off = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 4095));
        if (cur_pages == 0)
            return $urandom_range(0, 1) ? cur_base : $urandom;
        case ($urandom_range(0, 9))
            7: begin
                case ($urandom_range(0, 3))
                    0:       return cur_base + (cur_pages << PAGE_SHIFT);
                    1:       return cur_base + (cur_pages << PAGE_SHIFT) - 1;
                    2:       return cur_base - 1;
                    default: return cur_base;
                endcase
            end
            8, 9: return $urandom;
            default: begin
                lo_idx = 0;
                hi_idx = cur_pages - 1;
                if ($urandom_range(0, 1) && cur_rsv < cur_pages) begin
                    lo_idx = cur_rsv;
                    if (cur_rsv + 63 < hi_idx)
                        hi_idx = cur_rsv + 63;
                end
                idx = $urandom_range(lo_idx, hi_idx);
                return cur_base + (idx << PAGE_SHIFT) + page_off;
            end
        endcase
    endfunction

    // One region setting followed by a run of mixed requests
    task automatic run_phase(input int unsigned count);
        logic [31:0] base;
        int unsigned pages;
        int unsigned eff;
        int unsigned rsv;
        int unsigned alloc_pct;
        logic        cmd;
        case ($urandom_range(0, 9))
            0:          pages = $urandom_range(1, 8);
            1, 2, 3, 4: pages = $urandom_range(1, 40);
            5, 6, 7:    pages = $urandom_range(41, 700);
            8:          pages = $urandom_range(0, 65535);
            default:    pages = MAX_PAGES;
        endcase
        eff = pages > MAX_PAGES ? MAX_PAGES : pages;
        case ($urandom_range(0, 7))
            0:       rsv = 0;
            1:       rsv = eff == 0 ? 0 : eff - 1;
            2:       rsv = $urandom_range(0, 65535);
            default: rsv = $urandom_range(0, eff < 16 ? eff : 16);
        endcase
        case ($urandom_range(0, 5))
            0:       base = 32'h0;
            1:       base = 32'hFFFF_F000;
            2:       base = $urandom_range(0, 32'hFFFF_F000);
            default: base = $urandom_range(0, 32'hFFFF_F000) & 32'hFFFF_F000;
        endcase
        alloc_pct = $urandom_range(30, 75);
        configure(base, pages, rsv);
        for (int k = 0; k < count; k++) begin
            if (RANDOM_ITEMS - items_sent <= QUIET_TAIL)
                quiet = 1'b1;
            // hold the result side off while requests keep coming
            if (!hold_done && items_sent >= 600 && k == 5) begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
            end
            // pause the request side until the block has emptied
            if (!pause_done && items_sent >= 1200 && k == 10) begin
                pause_done = 1'b1;
                idle_tx();
                wait (pending == 0);
                @(negedge aclk);
            end
            cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
            send_req(cmd, cmd == CMD_ALLOC ? $urandom : pick_free_address());
            items_sent++;
        end
    endtask

    initial begin : stimulus
        int unsigned count;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_BASE;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_ALLOC;
        quiet       = 1'b0;
        rx_hold_req = 1'b0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        items_sent  = 0;
        cur_base    = BASE_RESET;
        cur_pages   = PCNT_RESET;
        cur_rsv     = RSV_RESET;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Region as left by reset: first pages, unaligned free, both edges,
        // freeing a free page, then a reserved page with the count at zero
        send_req(CMD_ALLOC, 32'hFFFF_FFFF);
        send_req(CMD_ALLOC, 32'h0);
        send_req(CMD_FREE, cur_base + (9 << PAGE_SHIFT) + 32'hFFF);
        send_req(CMD_FREE, cur_base - 1);
        send_req(CMD_FREE, cur_base + (cur_pages << PAGE_SHIFT));
        send_req(CMD_FREE, cur_base + (cur_pages << PAGE_SHIFT) - 1);
        send_req(CMD_FREE, cur_base);
        send_req(CMD_ALLOC, 32'h5555_5555);

        // Region at the top of the address space, wrapping past the end
        configure(32'hFFFF_F000, 3, 0);
        repeat (4) send_req(CMD_ALLOC, 32'h0);
        send_req(CMD_FREE, 32'hFFFF_F800);
        send_req(CMD_FREE, 32'h0);
        send_req(CMD_FREE, 32'hFFFF_FFFF);

        // Empty region
        configure(32'h0, 0, 0);
        send_req(CMD_ALLOC, 32'h0);
        send_req(CMD_FREE, 32'h0);

        // Page count beyond the map, reserved pages beyond the region
        configure(32'h0, 16'hFFFF, 16'hFFFF);
        send_req(CMD_ALLOC, 32'hAAAA_AAAA);
        send_req(CMD_FREE, 32'hFFFF_FFFF);
        send_req(CMD_FREE, (MAX_PAGES << PAGE_SHIFT) - 1);

        // Random phases
        while (items_sent < RANDOM_ITEMS) begin
            count = $urandom_range(60, 140);
            if (count > RANDOM_ITEMS - items_sent)
                count = RANDOM_ITEMS - items_sent;
            run_phase(count);
        end

        drain();
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Give up after far longer than the slowest correct run
    initial begin : watchdog
        #25_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
